/* rtl/affine_transform_3d_points_macros.svh */
// Assertion macros for the transform pipeline, used in atp_div.
// Each macro expects i_clk and i_rst_n in the module that uses it.
`ifndef AFFINE_TRANSFORM_3D_POINTS_MACROS_SVH
`define AFFINE_TRANSFORM_3D_POINTS_MACROS_SVH
// The property must hold in the same cycle as the condition.
`define ATP_ASSERT_NOW(name, cond, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("pipeline check failed");
// The property must hold in the cycle after the condition.
`define ATP_ASSERT_NEXT(name, cond, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("pipeline check failed");
`endif

/* rtl/atp_pkg.sv */
`default_nettype none
package atp_pkg;
    localparam int DEF_COORD_WIDTH    = 32;
    localparam int DEF_AXIS_FRAC_BITS = 14;
    localparam int SCALE_FRAC_BITS    = 8;
    localparam int LANE_W             = 16;
    localparam int CFG_IDX_W          = 3;
    localparam int CFG_DATA_W         = 48;

    localparam logic [CFG_IDX_W-1:0] REG_BASIS_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASIS_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 3'd5;

    localparam logic [CFG_DATA_W-1:0] BASIS_X_RST = 48'd16384;
    localparam logic [CFG_DATA_W-1:0] BASIS_Y_RST = 48'd1073741824;
    localparam logic [CFG_DATA_W-1:0] SCALE_RST   = 48'd1099528405248;

    localparam logic MODE_FWD = 1'b0;
    localparam logic MODE_INV = 1'b1;

    // Per-word sideband that travels with the data through every stage.
    typedef struct packed {
        logic mode;
        logic last;
    } t_tag;
endpackage
`default_nettype wire

/* rtl/atp_front.sv */
`default_nettype none
// Two stages: scale product or offset difference, then rounding and saturation.
module atp_front #(
    parameter int COORD_WIDTH = atp_pkg::DEF_COORD_WIDTH
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire atp_pkg::t_tag                       i_tag,
    input  wire logic signed [COORD_WIDTH-1:0]       i_point [3],
    input  wire logic signed [atp_pkg::LANE_W-1:0]   i_scale [3],
    input  wire logic signed [COORD_WIDTH-1:0]       i_offset [3],
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output atp_pkg::t_tag                            o_tag,
    output logic signed [COORD_WIDTH-1:0]            o_v [3]
);
    localparam int CW  = COORD_WIDTH;
    localparam int SFB = atp_pkg::SCALE_FRAC_BITS;
    localparam int PW  = CW + atp_pkg::LANE_W;
    localparam logic signed [PW:0] RND = (PW+1)'(1) << (SFB - 1);
    localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

    logic [1:0]              r_vld;
    logic                    en0;
    logic                    en1;
    atp_pkg::t_tag           r_tg0;
    atp_pkg::t_tag           r_tg1;
    logic signed [PW-1:0]    r_prod [3];
    logic signed [CW:0]      r_diff [3];
    logic signed [CW-1:0]    r_v [3];
    logic signed [CW-1:0]    n_v [3];
    logic signed [PW:0]      w_t [3];
    logic signed [PW:0]      w_sh [3];

    assign en1     = !r_vld[1] || i_ready;
    assign en0     = !r_vld[0] || en1;
    assign o_ready = en0;
    assign o_valid = r_vld[1];
    assign o_tag   = r_tg1;
    assign o_v     = r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en0) begin
                r_vld[0] <= i_valid;
            end
            if (en1) begin
                r_vld[1] <= r_vld[0];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_t[k]  = (PW+1)'(r_prod[k]) + RND;
            w_sh[k] = w_t[k] >>> SFB;
            if (r_tg0.mode == atp_pkg::MODE_INV) begin
                if (r_diff[k][CW] != r_diff[k][CW-1]) begin
                    n_v[k] = r_diff[k][CW] ? MINV : MAXV;
                end else begin
                    n_v[k] = r_diff[k][CW-1:0];
                end
            end else begin
                if ((w_sh[k][PW:CW-1] != '0) && (w_sh[k][PW:CW-1] != '1)) begin
                    n_v[k] = w_sh[k][PW] ? MINV : MAXV;
                end else begin
                    n_v[k] = w_sh[k][CW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0) begin
            r_tg0 <= i_tag;
            for (int k = 0; k < 3; k++) begin
                r_prod[k] <= PW'(i_point[k]) * PW'(i_scale[k]);
                r_diff[k] <= (CW+1)'(i_point[k]) - (CW+1)'(i_offset[k]);
            end
        end
        if (en1) begin
            r_tg1 <= r_tg0;
            r_v   <= n_v;
        end
    end
endmodule
`default_nettype wire

/* rtl/atp_rot.sv */
`default_nettype none
// Two stages: nine coefficient products, then three rounded sums.
module atp_rot #(
    parameter int COORD_WIDTH    = atp_pkg::DEF_COORD_WIDTH,
    parameter int AXIS_FRAC_BITS = atp_pkg::DEF_AXIS_FRAC_BITS
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire logic                                       i_valid,
    output logic                                            o_ready,
    input  wire atp_pkg::t_tag                              i_tag,
    input  wire logic signed [COORD_WIDTH-1:0]              i_v [3],
    input  wire logic signed [atp_pkg::LANE_W-1:0]          i_basis [3][3],
    output logic                                            o_valid,
    input  wire logic                                       i_ready,
    output atp_pkg::t_tag                                   o_tag,
    output logic signed [COORD_WIDTH+17-AXIS_FRAC_BITS:0]   o_sum [3]
);
    localparam int CW = COORD_WIDTH;
    localparam int AF = AXIS_FRAC_BITS;
    localparam int PW = CW + atp_pkg::LANE_W;
    localparam int SW = PW + 2 - AF;
    localparam logic signed [PW+1:0] HALF = (PW+2)'(1) << (AF - 1);

    logic [1:0]                          r_vld;
    logic                                en0;
    logic                                en1;
    atp_pkg::t_tag                       r_tg0;
    atp_pkg::t_tag                       r_tg1;
    logic signed [atp_pkg::LANE_W-1:0]   w_coef [3][3];
    logic signed [PW-1:0]                r_prod [3][3];
    logic signed [PW+1:0]                w_acc [3];
    logic signed [PW+1:0]                w_sh [3];
    logic signed [SW-1:0]                r_sum [3];

    assign en1     = !r_vld[1] || i_ready;
    assign en0     = !r_vld[0] || en1;
    assign o_ready = en0;
    assign o_valid = r_vld[1];
    assign o_tag   = r_tg1;
    assign o_sum   = r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en0) begin
                r_vld[0] <= i_valid;
            end
            if (en1) begin
                r_vld[1] <= r_vld[0];
            end
        end
    end

    // The inverse uses the basis rows, the forward transform its columns.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                w_coef[k][j] = (i_tag.mode == atp_pkg::MODE_INV) ? i_basis[k][j]
                                                                 : i_basis[j][k];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_acc[k] = (PW+2)'(r_prod[k][0]) + (PW+2)'(r_prod[k][1])
                     + (PW+2)'(r_prod[k][2]) + HALF;
            w_sh[k]  = w_acc[k] >>> AF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0) begin
            r_tg0 <= i_tag;
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[k][j] <= PW'(i_v[j]) * PW'(w_coef[k][j]);
                end
            end
        end
        if (en1) begin
            r_tg1 <= r_tg0;
            for (int k = 0; k < 3; k++) begin
                r_sum[k] <= w_sh[k][SW-1:0];
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/atp_div.sv */
`default_nettype none
`include "affine_transform_3d_points_macros.svh"
// Offset add for the forward transform, and a radix-2 restoring divider,
// one quotient bit per stage, for the inverse scale.
module atp_div #(
    parameter int COORD_WIDTH    = atp_pkg::DEF_COORD_WIDTH,
    parameter int AXIS_FRAC_BITS = atp_pkg::DEF_AXIS_FRAC_BITS
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire logic                                       i_valid,
    output logic                                            o_ready,
    input  wire atp_pkg::t_tag                              i_tag,
    input  wire logic signed [COORD_WIDTH+17-AXIS_FRAC_BITS:0] i_sum [3],
    input  wire logic signed [atp_pkg::LANE_W-1:0]          i_scale [3],
    input  wire logic signed [COORD_WIDTH-1:0]              i_offset [3],
    output logic                                            o_valid,
    input  wire logic                                       i_ready,
    output atp_pkg::t_tag                                   o_tag,
    output logic signed [COORD_WIDTH-1:0]                   o_result [3]
);
    localparam int CW  = COORD_WIDTH;
    localparam int SFB = atp_pkg::SCALE_FRAC_BITS;
    localparam int DW  = atp_pkg::LANE_W;
    localparam int SW  = CW + 18 - AXIS_FRAC_BITS;
    localparam int AW  = ((SW > CW) ? SW : CW) + 1;
    localparam int LW  = (SW > CW + 8) ? SW : CW + 8;
    localparam int MW  = CW + 7;
    localparam int NW  = MW + SFB;
    localparam logic signed [LW-1:0] LIM  = LW'(1) << (CW + 6);
    localparam logic signed [LW-1:0] NLIM = -LIM;
    localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        logic signed [CW-1:0] fwd;
        logic [NW-1:0]        num;
        logic [DW-1:0]        rem;
        logic [DW-1:0]        dvs;
        logic                 neg;
        logic                 dz;
        logic                 rz;
    } t_lane;

    function automatic t_lane div_step(input t_lane x);
        t_lane       y;
        logic [DW:0] t;
        logic [DW:0] d;
        logic        ge;
        y  = x;
        t  = {x.rem, x.num[NW-1]};
        d  = t - {1'b0, x.dvs};
        ge = (t >= {1'b0, x.dvs});
        y.rem = ge ? d[DW-1:0] : t[DW-1:0];
        y.num = {x.num[NW-2:0], ge};
        return y;
    endfunction

    function automatic logic signed [CW-1:0] div_final(input t_lane x);
        logic signed [NW:0] q;
        logic signed [NW:0] sv;
        q  = {1'b0, x.num};
        sv = x.neg ? -q : q;
        if (x.dz) begin
            return x.rz ? '0 : (x.neg ? MINV : MAXV);
        end
        if ((sv[NW:CW-1] != '0) && (sv[NW:CW-1] != '1)) begin
            return sv[NW] ? MINV : MAXV;
        end
        return sv[CW-1:0];
    endfunction

    logic [NW+1:0]          r_vld;
    logic [NW+1:0]          en;
    atp_pkg::t_tag          r_tg [0:NW];
    t_lane                  r_ln [0:NW][3];
    t_lane                  n_ln0 [3];
    atp_pkg::t_tag          r_tgf;
    logic signed [CW-1:0]   r_res [3];
    logic signed [AW-1:0]   w_fs [3];
    logic signed [LW-1:0]   w_rw [3];
    logic signed [LW-1:0]   w_rc [3];

    always_comb begin
        en[NW+1] = !r_vld[NW+1] || i_ready;
        for (int s = NW; s >= 0; s--) begin
            en[s] = !r_vld[s] || en[s+1];
        end
    end

    assign o_ready  = en[0];
    assign o_valid  = r_vld[NW+1];
    assign o_tag    = r_tgf;
    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int s = 1; s <= NW + 1; s++) begin
                if (en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // Entry: forward sum with offset, or clamp and split into sign and magnitude.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_fs[k] = AW'(i_sum[k]) + AW'(i_offset[k]);
            if ((w_fs[k][AW-1:CW-1] != '0) && (w_fs[k][AW-1:CW-1] != '1)) begin
                n_ln0[k].fwd = w_fs[k][AW-1] ? MINV : MAXV;
            end else begin
                n_ln0[k].fwd = w_fs[k][CW-1:0];
            end
            w_rw[k] = LW'(i_sum[k]);
            if (w_rw[k] > LIM) begin
                w_rc[k] = LIM;
            end else if (w_rw[k] < NLIM) begin
                w_rc[k] = NLIM;
            end else begin
                w_rc[k] = w_rw[k];
            end
            n_ln0[k].num = {(w_rc[k][LW-1] ? MW'(-w_rc[k]) : MW'(w_rc[k])), {SFB{1'b0}}};
            n_ln0[k].rem = '0;
            n_ln0[k].dvs = i_scale[k][DW-1] ? DW'(-i_scale[k]) : DW'(i_scale[k]);
            n_ln0[k].neg = w_rc[k][LW-1] ^ i_scale[k][DW-1];
            n_ln0[k].dz  = (i_scale[k] == '0);
            n_ln0[k].rz  = (i_sum[k] == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_tg[0] <= i_tag;
            r_ln[0] <= n_ln0;
        end
        for (int s = 1; s <= NW; s++) begin
            if (en[s]) begin
                r_tg[s] <= r_tg[s-1];
                for (int k = 0; k < 3; k++) begin
                    r_ln[s][k] <= div_step(r_ln[s-1][k]);
                end
            end
        end
        if (en[NW+1]) begin
            r_tgf <= r_tg[NW];
            for (int k = 0; k < 3; k++) begin
                r_res[k] <= (r_tg[NW].mode == atp_pkg::MODE_INV) ? div_final(r_ln[NW][k])
                                                                 : r_ln[NW][k].fwd;
            end
        end
    end

    `ATP_ASSERT_NOW(a_full_when_blocked, !o_ready, (&r_vld) && !i_ready)
    `ATP_ASSERT_NEXT(a_result_held, r_vld[NW+1] && !i_ready, $stable(r_res[0]) && $stable(r_res[2]))
    `ATP_ASSERT_NEXT(a_zero_over_zero, r_vld[NW] && en[NW+1] && (r_tg[NW].mode == atp_pkg::MODE_INV) && r_ln[NW][1].dz && r_ln[NW][1].rz, r_res[1] == '0)
endmodule
`default_nettype wire

/* rtl/affine_transform_3d_points.sv */
`default_nettype none
// 3D point transform, one point per word, signed fixed point with 16 fraction bits.
// Input channel: i_valid/o_stall with mode, point x/y/z and batch_end; a word is
// taken at a clock edge where i_valid is high and o_stall is low. Mode 0 scales,
// rotates by the basis X, Y, Z = X cross Y and adds the offset; mode 1 subtracts
// the offset, rotates by the transposed basis and divides by the scale.
// Output channel: o_valid/i_stall with result x/y/z and result_last.
// Configuration: i_cfg_valid/o_cfg_ready with a register index and data; writes
// are taken in every cycle and must only be made while no word is in flight.
// The pipeline has two front stages, two rotation stages, an entry stage, one divider
// stage per quotient bit (COORD_WIDTH + 15 of them) and the output register.
// Throughput is one word per cycle while the receiver does not stall. When the
// receiver stalls, the output register holds its word and earlier stages keep
// filling bubbles; o_stall rises only when every stage is occupied.
// The synchronous reset empties the pipeline and loads the default identity
// basis, unit scale and zero offset. Z axis is rebuilt in the cycle after a write.
module affine_transform_3d_points #(
    parameter int COORD_WIDTH    = atp_pkg::DEF_COORD_WIDTH,
    parameter int AXIS_FRAC_BITS = atp_pkg::DEF_AXIS_FRAC_BITS
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic                                 i_mode,
    input  wire logic signed [COORD_WIDTH-1:0]        i_point_x,
    input  wire logic signed [COORD_WIDTH-1:0]        i_point_y,
    input  wire logic signed [COORD_WIDTH-1:0]        i_point_z,
    input  wire logic                                 i_batch_end,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic signed [COORD_WIDTH-1:0]             o_result_x,
    output logic signed [COORD_WIDTH-1:0]             o_result_y,
    output logic signed [COORD_WIDTH-1:0]             o_result_z,
    output logic                                      o_result_last,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [atp_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [atp_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    localparam int CW = COORD_WIDTH;
    localparam int AF = AXIS_FRAC_BITS;
    localparam int LW = atp_pkg::LANE_W;
    localparam int XW = 2 * LW + 2;
    localparam logic signed [XW-1:0] XHALF = XW'(1) << (AF - 1);
    localparam int SW = CW + 18 - AF;

    // Configuration registers.
    logic [atp_pkg::CFG_DATA_W-1:0] r_basis_x;
    logic [atp_pkg::CFG_DATA_W-1:0] r_basis_y;
    logic [atp_pkg::CFG_DATA_W-1:0] r_scale;
    logic signed [CW-1:0]           r_off [3];
    logic signed [LW-1:0]           r_bz [3];
    logic signed [LW-1:0]           n_bz [3];

    logic signed [LW-1:0]           w_basis [3][3];
    logic signed [LW-1:0]           w_scale [3];
    logic signed [CW-1:0]           w_point [3];
    logic signed [XW-1:0]           w_cr [3];
    logic signed [XW-1:0]           w_crs [3];

    atp_pkg::t_tag                  w_in_tag;
    logic                           w_fr_ready;
    logic                           w_fr_valid;
    atp_pkg::t_tag                  w_fr_tag;
    logic signed [CW-1:0]           w_fr_v [3];
    logic                           w_rt_ready;
    logic                           w_rt_valid;
    atp_pkg::t_tag                  w_rt_tag;
    logic signed [SW-1:0]           w_rt_sum [3];
    logic                           w_dv_ready;
    atp_pkg::t_tag                  w_dv_tag;
    logic signed [CW-1:0]           w_res [3];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_basis_x <= atp_pkg::BASIS_X_RST;
            r_basis_y <= atp_pkg::BASIS_Y_RST;
            r_scale   <= atp_pkg::SCALE_RST;
            r_off[0]  <= '0;
            r_off[1]  <= '0;
            r_off[2]  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                atp_pkg::REG_BASIS_X:  r_basis_x <= i_cfg_data;
                atp_pkg::REG_BASIS_Y:  r_basis_y <= i_cfg_data;
                atp_pkg::REG_SCALE:    r_scale   <= i_cfg_data;
                atp_pkg::REG_OFFSET_X: r_off[0]  <= i_cfg_data[CW-1:0];
                atp_pkg::REG_OFFSET_Y: r_off[1]  <= i_cfg_data[CW-1:0];
                atp_pkg::REG_OFFSET_Z: r_off[2]  <= i_cfg_data[CW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_basis[0][c] = r_basis_x[LW*c +: LW];
            w_basis[1][c] = r_basis_y[LW*c +: LW];
            w_basis[2][c] = r_bz[c];
            w_scale[c]    = r_scale[LW*c +: LW];
        end
    end

    // Z axis = X cross Y, each component rounded half up and clipped to a lane.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_cr[c] = XW'(w_basis[0][(c+1)%3]) * XW'(w_basis[1][(c+2)%3])
                    - XW'(w_basis[0][(c+2)%3]) * XW'(w_basis[1][(c+1)%3]) + XHALF;
            w_crs[c] = w_cr[c] >>> AF;
            if ((w_crs[c][XW-1:LW-1] != '0) && (w_crs[c][XW-1:LW-1] != '1)) begin
                n_bz[c] = w_crs[c][XW-1] ? {1'b1, {(LW-1){1'b0}}} : {1'b0, {(LW-1){1'b1}}};
            end else begin
                n_bz[c] = w_crs[c][LW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bz <= n_bz;
    end

    assign w_in_tag.mode = i_mode;
    assign w_in_tag.last = i_batch_end;
    assign w_point[0]    = i_point_x;
    assign w_point[1]    = i_point_y;
    assign w_point[2]    = i_point_z;
    assign o_stall       = !w_fr_ready;

    atp_front #(
        .COORD_WIDTH (CW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (w_fr_ready),
        .i_tag    (w_in_tag),
        .i_point  (w_point),
        .i_scale  (w_scale),
        .i_offset (r_off),
        .o_valid  (w_fr_valid),
        .i_ready  (w_rt_ready),
        .o_tag    (w_fr_tag),
        .o_v      (w_fr_v)
    );

    atp_rot #(
        .COORD_WIDTH    (CW),
        .AXIS_FRAC_BITS (AF)
    ) u_rot (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_fr_valid),
        .o_ready  (w_rt_ready),
        .i_tag    (w_fr_tag),
        .i_v      (w_fr_v),
        .i_basis  (w_basis),
        .o_valid  (w_rt_valid),
        .i_ready  (w_dv_ready),
        .o_tag    (w_rt_tag),
        .o_sum    (w_rt_sum)
    );

    atp_div #(
        .COORD_WIDTH    (CW),
        .AXIS_FRAC_BITS (AF)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_rt_valid),
        .o_ready  (w_dv_ready),
        .i_tag    (w_rt_tag),
        .i_sum    (w_rt_sum),
        .i_scale  (w_scale),
        .i_offset (r_off),
        .o_valid  (o_valid),
        .i_ready  (!i_stall),
        .o_tag    (w_dv_tag),
        .o_result (w_res)
    );

    assign o_result_x    = w_res[0];
    assign o_result_y    = w_res[1];
    assign o_result_z    = w_res[2];
    assign o_result_last = w_dv_tag.last;
endmodule
`default_nettype wire
